[hdl/pli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int QUOT_W = 40;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 4;
    localparam int PC_W   = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_EXTRAPOLATE = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ADDR_LAST = 2'd0,
        ADDR_NEXT = 2'd1,
        ADDR_CUR  = 2'd2
    } addr_sel_t;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_LAST_RD   = 13'b0000000000010,
        S_LAST_CMP  = 13'b0000000000100,
        S_SCAN_RD   = 13'b0000000001000,
        S_SCAN_CMP  = 13'b0000000010000,
        S_LEFT_RD   = 13'b0000000100000,
        S_RIGHT_RD  = 13'b0000001000000,
        S_RIGHT_CAP = 13'b0000010000000,
        S_PREP      = 13'b0000100000000,
        S_MUL       = 13'b0001000000000,
        S_DIV_INIT  = 13'b0010000000000,
        S_DIV       = 13'b0100000000000,
        S_FIN       = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic      start;
        logic      set_last;
        logic      inc;
        addr_sel_t addr_sel;
        logic      cap_left;
        logic      cap_right;
        logic      prep;
        logic      mul;
        logic      div_init;
        logic      div_step;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic x_ge_rd;
        logic x_gt_rd;
        logic scan_more;
        logic degen;
        logic ovf;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

[hdl/pli_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_if
// Request, result and register write channels of the interpolator.
// ----------------------------------------------------------------------------
interface pli_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;

    modport source (output valid, opcode, point_index, point_x, point_y, query_x,
                    input ready);
    modport sink   (input valid, opcode, point_index, point_x, point_y, query_x,
                    output ready);
endinterface

interface pli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_y;
    logic               degenerate_interval;
    logic               saturated;

    modport source (output valid, result_y, degenerate_interval, saturated,
                    input ready);
    modport sink   (input valid, result_y, degenerate_interval, saturated,
                    output ready);
endinterface

interface pli_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [4:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/pli_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/pli_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for table scan, multiplication, division and result hand-off.
// ----------------------------------------------------------------------------
module pli_ctrl
    import pli_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  logic    in_opcode,
    input  status_t st,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.addr_sel = ADDR_CUR;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_opcode == OP_QUERY)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_LAST_RD;
                end
            end
            S_LAST_RD:
            begin
                cmd.addr_sel = ADDR_LAST;
                state_next   = S_LAST_CMP;
            end
            S_LAST_CMP:
            begin
                if (st.x_ge_rd)
                begin
                    cmd.set_last = 1'b1;
                    state_next   = S_LEFT_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.addr_sel = ADDR_NEXT;
                state_next   = st.scan_more ? S_SCAN_CMP : S_LEFT_RD;
            end
            S_SCAN_CMP:
            begin
                if (st.x_gt_rd)
                begin
                    cmd.inc    = 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_LEFT_RD;
                end
            end
            S_LEFT_RD:
            begin
                cmd.addr_sel = ADDR_CUR;
                state_next   = S_RIGHT_RD;
            end
            S_RIGHT_RD:
            begin
                cmd.addr_sel = ADDR_NEXT;
                cmd.cap_left = 1'b1;
                state_next   = S_RIGHT_CAP;
            end
            S_RIGHT_CAP:
            begin
                cmd.cap_right = 1'b1;
                state_next    = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = st.degen ? S_FIN : S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = st.ovf ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/pli_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_dp
// Breakpoint table, interval registers, multiplier, serial divider, output.
// ----------------------------------------------------------------------------
module pli_dp
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  st,
    input  logic                     in_fire,
    input  logic                     in_opcode,
    input  logic [IDX_W-1:0]         in_point_index,
    input  logic signed [DATA_W-1:0] in_point_x,
    input  logic signed [DATA_W-1:0] in_point_y,
    input  logic signed [DATA_W-1:0] in_query_x,
    input  logic                     cfg_fire,
    input  logic                     cfg_index,
    input  logic [PC_W-1:0]          cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_result_y,
    output logic                     out_degenerate,
    output logic                     out_saturated
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = QUOT_W + 2;

    logic                     ext_reg;
    logic [PC_W-1:0]          pc_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [AW-1:0]            idx_reg;
    logic signed [DATA_W-1:0] xl_reg, yl_reg, xr_reg, yr_reg;
    logic [DATA_W-1:0]        mdx_reg, mdy_reg, mdq_reg;
    logic                     neg_reg, degen_reg;
    logic signed [DATA_W-1:0] ybase_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [QUOT_W-1:0]        bits_reg, q_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     degen_out_reg, sat_out_reg;

    int                       n_int;
    logic [AW-1:0]            n_m2;
    logic [AW-1:0]            raddr;
    logic                     we;
    logic [2*DATA_W-1:0]      rdata;
    logic signed [DATA_W-1:0] rd_x, rd_y;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b0;
            pc_reg  <= PC_W'(2);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_EXTRAPOLATE: ext_reg <= cfg_data[0];
                REG_POINT_COUNT: pc_reg  <= cfg_data;
                default:         ext_reg <= ext_reg;
            endcase
        end
    end

    always_comb
    begin
        n_int = int'(pc_reg);
        if (n_int < 2)
        begin
            n_int = 2;
        end
        if (n_int > MAX_POINTS)
        begin
            n_int = MAX_POINTS;
        end
    end

    assign n_m2 = AW'(n_int - 2);

    assign we = in_fire && (in_opcode == OP_LOAD) && (int'(in_point_index) < MAX_POINTS);

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_LAST: raddr = n_m2;
            ADDR_NEXT: raddr = idx_reg + AW'(1);
            ADDR_CUR:  raddr = idx_reg;
            default:   raddr = idx_reg;
        endcase
    end

    pli_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(in_point_index)),
        .wdata ({in_point_x, in_point_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_x = rdata[2*DATA_W-1:DATA_W];
    assign rd_y = rdata[DATA_W-1:0];

    // Interval preparation: clamp to end values unless extrapolation is enabled, then differences and signs.
    logic                     lt_l, gt_r;
    logic signed [DATA_W-1:0] ybase_c, ytop_c;
    logic signed [DATA_W:0]   dx_c, dy_c, dq_c, adx, ady, adq;

    always_comb
    begin
        lt_l    = x_reg < xl_reg;
        gt_r    = x_reg > xr_reg;
        ybase_c = (!ext_reg && gt_r && !lt_l) ? yr_reg : yl_reg;
        ytop_c  = (!ext_reg && lt_l) ? yl_reg : yr_reg;
        dx_c    = {xr_reg[DATA_W-1], xr_reg} - {xl_reg[DATA_W-1], xl_reg};
        dy_c    = {ytop_c[DATA_W-1], ytop_c} - {ybase_c[DATA_W-1], ybase_c};
        dq_c    = {x_reg[DATA_W-1], x_reg} - {xl_reg[DATA_W-1], xl_reg};
        adx     = dx_c[DATA_W] ? -dx_c : dx_c;
        ady     = dy_c[DATA_W] ? -dy_c : dy_c;
        adq     = dq_c[DATA_W] ? -dq_c : dq_c;
    end

    // One step of restoring division.
    logic [DATA_W:0] rem2, diff;
    logic            ge;

    always_comb
    begin
        rem2 = {rem_reg, bits_reg[QUOT_W-1]};
        diff = rem2 - {1'b0, mdx_reg};
        ge   = rem2 >= {1'b0, mdx_reg};
    end

    // Final sum and saturation.
    logic signed [SW-1:0]     sq, sum;
    logic signed [DATA_W-1:0] res_c;
    logic                     sat_c;

    always_comb
    begin
        sq  = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        sum = SW'(ybase_reg) + sq;
        sat_c = 1'b0;
        res_c = sum[DATA_W-1:0];
        if (degen_reg)
        begin
            res_c = ybase_reg;
        end
        else if (ovf_reg)
        begin
            sat_c = 1'b1;
            res_c = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (sum > SW'(32'sh7FFFFFFF))
        begin
            sat_c = 1'b1;
            res_c = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (sum < SW'(32'sh80000000))
        begin
            sat_c = 1'b1;
            res_c = {1'b1, {(DATA_W-1){1'b0}}};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (cmd.set_last)
            begin
                idx_reg <= n_m2;
            end
            else if (cmd.inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.prep)
            begin
                degen_reg <= (dx_c == '0);
            end
            if (cmd.div_init)
            begin
                ovf_reg <= st.ovf;
                cnt_reg <= CNT_W'(QUOT_W);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= in_query_x;
        end
        if (cmd.cap_left)
        begin
            xl_reg <= rd_x;
            yl_reg <= rd_y;
        end
        if (cmd.cap_right)
        begin
            xr_reg <= rd_x;
            yr_reg <= rd_y;
        end
        if (cmd.prep)
        begin
            mdx_reg   <= adx[DATA_W-1:0];
            mdy_reg   <= ady[DATA_W-1:0];
            mdq_reg   <= adq[DATA_W-1:0];
            neg_reg   <= dy_c[DATA_W] ^ dq_c[DATA_W] ^ dx_c[DATA_W];
            ybase_reg <= ybase_c;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mdy_reg) * PROD_W'(mdq_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= DATA_W'(prod_reg[PROD_W-1:QUOT_W]);
            bits_reg <= prod_reg[QUOT_W-1:0];
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? diff[DATA_W-1:0] : rem2[DATA_W-1:0];
            bits_reg <= {bits_reg[QUOT_W-2:0], 1'b0};
            q_reg    <= {q_reg[QUOT_W-2:0], ge};
        end
        if (cmd.load_out)
        begin
            res_reg       <= res_c;
            degen_out_reg <= degen_reg;
            sat_out_reg   <= sat_c;
        end
    end

    always_comb
    begin
        st.x_ge_rd   = x_reg >= rd_x;
        st.x_gt_rd   = x_reg > rd_x;
        st.scan_more = (int'(idx_reg) + 2) < n_int;
        st.degen     = degen_reg;
        // The quotient reaches 2^40 exactly when the product's top bits reach the divisor.
        st.ovf       = DATA_W'(prod_reg[PROD_W-1:QUOT_W]) >= mdx_reg;
        st.div_done  = (cnt_reg == CNT_W'(1));
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_result_y   = res_reg;
    assign out_degenerate = degen_out_reg;
    assign out_saturated  = sat_out_reg;

    a_degen_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && degen_out_reg |-> !sat_out_reg)
        else $error("degenerate result flagged as saturated");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> idx_reg <= n_m2)
        else $error("interval index beyond last interval");

    a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && !degen_reg && !ovf_reg |-> cnt_reg == '0)
        else $error("result loaded before division finished");

endmodule

[hdl/piecewise_linear_interpolator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Breakpoint table with interval scan and exact Q16.16 linear interpolation.
// ----------------------------------------------------------------------------
//  Channel  Dir  Content
//  din      in   opcode, point_index, point_x, point_y, query_x
//  dout     out  result_y, degenerate_interval, saturated
//  cfg      in   index (0 extrapolate_enable, 1 point_count), data
//
// A load request is written in the cycle it is accepted and the core is free
// again next cycle. A query scans the breakpoints one at a time through the
// single table read port and then runs the 40-step serial divider. Reset
// clears control state only; the table is undefined until loaded. A stalled
// result waits in the output register while the next request is accepted;
// the following query waits at its end.
module piecewise_linear_interpolator_core
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input logic       clk,
    input logic       rst_n,
    pli_in_if.sink    din,
    pli_out_if.source dout,
    pli_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t st;
    logic    in_ready;
    logic    in_fire;

    assign din.ready = in_ready;
    assign cfg.ready = 1'b1;
    assign in_fire   = din.valid && in_ready;

    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_opcode (din.opcode),
        .st        (st),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    pli_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .in_fire        (in_fire),
        .in_opcode      (din.opcode),
        .in_point_index (din.point_index),
        .in_point_x     (din.point_x),
        .in_point_y     (din.point_y),
        .in_query_x     (din.query_x),
        .cfg_fire       (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (dout.valid),
        .out_ready      (dout.ready),
        .out_result_y   (dout.result_y),
        .out_degenerate (dout.degenerate_interval),
        .out_saturated  (dout.saturated)
    );

endmodule
